// ===== sv/cfc_pkg.sv =====
// Shared types and constants for the camera frame capture decimator.
`timescale 1ns / 1ps

package cfc_pkg;

  localparam int DIV_W   = 7;
  localparam int THR_W   = 19;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 10;
  localparam int PIX_W   = 8;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;

  localparam logic [DIV_W-1:0] RST_DIV_X           = 7'd2;
  localparam logic [DIV_W-1:0] RST_DIV_Y           = 7'd2;
  localparam logic             RST_TRANSMIT_ENABLE = 1'b0;
  localparam logic [THR_W-1:0] RST_BLOCK_THRESHOLD = 19'd3200;

  // Window sizes and wide-mode sampling constants
  localparam logic [COL_W-1:0] WIN_X_NARROW = 11'd640;
  localparam logic [ROW_W-1:0] WIN_Y_NARROW = 10'd400;
  localparam logic [COL_W-1:0] WIN_X_WIDE   = 11'd1280;
  localparam logic [ROW_W-1:0] WIN_Y_WIDE   = 10'd800;
  localparam logic [DIV_W-1:0] WIDE_DIV_MIN = 7'd8;
  localparam logic [DIV_W-1:0] WIDE_PH_RUN  = 7'd3;
  localparam logic [DIV_W-1:0] WIDE_PH_TAIL = 7'd9;
  localparam logic [ROW_W-1:0] ROW_MAX      = 10'd1023;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    REG_DIV_X           = 2'd0,
    REG_DIV_Y           = 2'd1,
    REG_TRANSMIT_ENABLE = 2'd2,
    REG_BLOCK_THRESHOLD = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SKIP_HIGH = 3'd1,
    PH_SKIP_LOW  = 3'd2,
    PH_ARMED     = 3'd3,
    PH_ACTIVE    = 3'd4,
    PH_SENT      = 3'd5
  } phase_t;

  typedef struct packed {
    logic [DIV_W-1:0] div_x;
    logic [DIV_W-1:0] div_y;
    logic             transmit_enable;
    logic [THR_W-1:0] block_threshold;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic             vsync;
    logic             hsync;
    logic [PIX_W-1:0] pixel_data;
  } item_t;

  typedef struct packed {
    logic pixel_store;
    logic block_ready;
    logic frame_done;
  } res_flags_t;

endpackage

// ===== sv/cfc_regs.sv =====
// APB-style configuration register file.
`timescale 1ns / 1ps

module cfc_regs import cfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.div_x           <= RST_DIV_X;
      cfg_r.div_y           <= RST_DIV_Y;
      cfg_r.transmit_enable <= RST_TRANSMIT_ENABLE;
      cfg_r.block_threshold <= RST_BLOCK_THRESHOLD;
    end else if (wr_en) begin
      case (idx)
        REG_DIV_X:           cfg_r.div_x           <= pwdata[DIV_W-1:0];
        REG_DIV_Y:           cfg_r.div_y           <= pwdata[DIV_W-1:0];
        REG_TRANSMIT_ENABLE: cfg_r.transmit_enable <= pwdata[0];
        REG_BLOCK_THRESHOLD: cfg_r.block_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DIV_X:           prdata = APB_DW'(cfg_r.div_x);
      REG_DIV_Y:           prdata = APB_DW'(cfg_r.div_y);
      REG_TRANSMIT_ENABLE: prdata = APB_DW'(cfg_r.transmit_enable);
      REG_BLOCK_THRESHOLD: prdata = APB_DW'(cfg_r.block_threshold);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== sv/cfc_core.sv =====
// Capture sequencer: phase state, counters and per-sample store decision.
`timescale 1ns / 1ps

module cfc_core import cfc_pkg::*; #(
  parameter int ADDRESS_BITS = 19
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  item_t                   item,
  input  cfg_t                    cfg,
  output logic                    res_emit,
  output res_flags_t              res_flags,
  output logic [PIX_W-1:0]        res_value,
  output logic [ADDRESS_BITS-1:0] res_addr
);

  localparam int CMP_W = (ADDRESS_BITS > THR_W) ? ADDRESS_BITS : THR_W;
  localparam logic [ADDRESS_BITS-1:0] ADDR_TOP = {ADDRESS_BITS{1'b1}};

  phase_t                  phase_r, phase_nxt;
  logic [COL_W-1:0]        col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]        row_cnt_r, row_cnt_nxt;
  logic [DIV_W-1:0]        col_ph_r, col_ph_nxt;
  logic [DIV_W-1:0]        row_ph_r, row_ph_nxt;
  logic [ADDRESS_BITS-1:0] store_cnt_r, store_cnt_nxt;

  logic             wide;
  logic [COL_W-1:0] lim_x;
  logic [ROW_W-1:0] lim_y;
  logic             in_window;
  logic             take;
  logic [DIV_W-1:0] col_ph_inc;
  logic [DIV_W-1:0] row_ph_inc;

  assign wide       = cfg.div_x >= WIDE_DIV_MIN;
  assign lim_x      = wide ? WIN_X_WIDE : WIN_X_NARROW;
  assign lim_y      = wide ? WIN_Y_WIDE : WIN_Y_NARROW;
  assign in_window  = (col_cnt_r < lim_x) && (row_cnt_r < lim_y);
  assign col_ph_inc = col_ph_r + 1'b1;
  assign row_ph_inc = row_ph_r + 1'b1;
  assign take = wide ? (((col_ph_r < WIDE_PH_RUN) || (col_ph_r == WIDE_PH_TAIL))
                        && (row_ph_r == '0))
                     : ((col_ph_r == '0) && (row_ph_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      col_ph_r    <= '0;
      row_ph_r    <= '0;
      store_cnt_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_ph_r    <= col_ph_nxt;
      row_ph_r    <= row_ph_nxt;
      store_cnt_r <= store_cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    col_ph_nxt    = col_ph_r;
    row_ph_nxt    = row_ph_r;
    store_cnt_nxt = store_cnt_r;
    res_flags     = '0;
    res_value     = '0;
    res_addr      = '0;

    if (step) begin
      if (item.kind == KIND_START) begin
        phase_nxt     = PH_SKIP_HIGH;
        col_cnt_nxt   = '0;
        row_cnt_nxt   = '0;
        col_ph_nxt    = '0;
        row_ph_nxt    = '0;
        store_cnt_nxt = '0;
      end else begin
        case (phase_r)
          PH_SKIP_HIGH: begin
            if (item.vsync) phase_nxt = PH_SKIP_LOW;
          end
          PH_SKIP_LOW: begin
            if (!item.vsync) begin
              phase_nxt     = PH_ARMED;
              col_cnt_nxt   = '0;
              row_cnt_nxt   = '0;
              col_ph_nxt    = '0;
              row_ph_nxt    = '0;
              store_cnt_nxt = '0;
            end
          end
          PH_ARMED, PH_ACTIVE, PH_SENT: begin
            if (item.vsync) begin
              if (item.hsync) begin
                if (in_window) begin
                  if (take) begin
                    res_flags.pixel_store = 1'b1;
                    res_value             = item.pixel_data;
                    res_addr              = store_cnt_r;
                    if (store_cnt_r < ADDR_TOP) store_cnt_nxt = store_cnt_r + 1'b1;
                  end
                  col_cnt_nxt = col_cnt_r + 1'b1;
                  col_ph_nxt  = (col_ph_inc == cfg.div_x) ? '0 : col_ph_inc;
                end
                if (phase_r == PH_ARMED) phase_nxt = PH_ACTIVE;
              end else begin
                if (col_cnt_r != '0) begin
                  if (row_cnt_r < ROW_MAX) row_cnt_nxt = row_cnt_r + 1'b1;
                  row_ph_nxt = (row_ph_inc == cfg.div_y) ? '0 : row_ph_inc;
                end else begin
                  row_ph_nxt = (row_ph_r == cfg.div_y) ? '0 : row_ph_r;
                end
                col_cnt_nxt = '0;
                col_ph_nxt  = '0;
              end
            end else begin
              col_cnt_nxt = '0;
              row_cnt_nxt = '0;
              col_ph_nxt  = '0;
              row_ph_nxt  = '0;
              if (phase_r != PH_ARMED) begin
                phase_nxt            = PH_IDLE;
                res_flags.frame_done = 1'b1;
              end
            end
            if ((phase_nxt == PH_ACTIVE) && cfg.transmit_enable &&
                (CMP_W'(store_cnt_nxt) == CMP_W'(cfg.block_threshold))) begin
              res_flags.block_ready = 1'b1;
              phase_nxt             = PH_SENT;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign res_emit = res_flags.pixel_store | res_flags.block_ready | res_flags.frame_done;

endmodule

// ===== sv/camera_frame_capture_decimator.sv =====
// Top level of the camera frame capture decimator: request registers and wiring.
`timescale 1ns / 1ps
// Path: an accepted sample request is loaded into the input register, and its result
//   is then loaded into the result register, which drives the outputs.
// Throughput: one request per cycle while out_stall is low; the sequencer step
//   between the two registers is combinational.
// Reset: synchronous, active low; clears the phase to idle, all counters, both
//   valid flags and the configuration registers to their defaults.

module camera_frame_capture_decimator import cfc_pkg::*; #(
  parameter int ADDRESS_BITS = 19
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // sample / start request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_kind,
  input  logic                    in_vsync,
  input  logic                    in_hsync,
  input  logic [PIX_W-1:0]        in_pixel_data,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_pixel_store,
  output logic [PIX_W-1:0]        out_pixel_value,
  output logic [ADDRESS_BITS-1:0] out_write_address,
  output logic                    out_block_ready,
  output logic                    out_frame_done,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  cfg_t cfg;

  // Input register: holds one request until the sequencer consumes it
  logic  in_valid_r, in_valid_nxt;
  item_t item_r;

  // Result register
  logic                    out_valid_r, out_valid_nxt;
  res_flags_t              out_flags_r;
  logic [PIX_W-1:0]        out_value_r;
  logic [ADDRESS_BITS-1:0] out_addr_r;

  logic                    advance;
  logic                    in_take;
  logic                    res_emit;
  res_flags_t              res_flags;
  logic [PIX_W-1:0]        res_value;
  logic [ADDRESS_BITS-1:0] res_addr;

  cfc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held request whenever the result register is free or is
  // being emptied this cycle; the sequencer steps on these cycles when a request is held.
  assign advance  = ~out_valid_r | ~out_stall;
  assign in_stall = in_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  cfc_core #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_valid_r & advance),
    .item      (item_r),
    .cfg       (cfg),
    .res_emit  (res_emit),
    .res_flags (res_flags),
    .res_value (res_value),
    .res_addr  (res_addr)
  );

  always_comb begin
    if (in_take)      in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
    else              in_valid_nxt = in_valid_r;
    // Drop requests that produce no result; hold the result while stalled
    out_valid_nxt = advance ? (in_valid_r & res_emit) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind       <= in_kind;
      item_r.vsync      <= in_vsync;
      item_r.hsync      <= in_hsync;
      item_r.pixel_data <= in_pixel_data;
    end
    if (advance) begin
      out_flags_r <= res_flags;
      out_value_r <= res_value;
      out_addr_r  <= res_addr;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_store   = out_flags_r.pixel_store;
  assign out_pixel_value   = out_value_r;
  assign out_write_address = out_addr_r;
  assign out_block_ready   = out_flags_r.block_ready;
  assign out_frame_done    = out_flags_r.frame_done;

endmodule
